// File: rtl/core/sffe_pkg.sv
// ----------------------------------------------------------------------------
// sffe_pkg
// Shared types, constants and the integer-to-single conversion function.
// ----------------------------------------------------------------------------
package sffe_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam logic [7:0] TAIL_B0 = 8'h00;
   localparam logic [7:0] TAIL_B1 = 8'h00;
   localparam logic [7:0] TAIL_B2 = 8'h80;
   localparam logic [7:0] TAIL_B3 = 8'h7F;

   typedef struct packed {
      logic [31:0] raw_value;
      logic        sample_valid;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_last;
   } rsp_type;

   // Encoded frame fragment for one request: up to ten bytes, count 4 or 10.
   typedef struct packed {
      logic [79:0] bytes;
      logic        last;
   } frag_type;

   // Convert unsigned 32-bit to IEEE-754 single, round to nearest even.
   function automatic logic [31:0] to_single(input logic [31:0] v);
      logic [4:0]  p;
      logic [31:0] norm;
      logic [23:0] m;
      logic [24:0] mr;
      logic        rnd;
      logic        stk;
      logic [7:0]  ex;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
      norm = v << (5'd31 - p);
      m = norm[31:8];
      rnd = norm[7];
      stk = |norm[6:0];
      mr = {1'b0, m} + 25'((rnd && (stk || m[0])) ? 1 : 0);
      ex = 8'd127 + {3'd0, p};
      if (mr[24]) begin
         ex = ex + 8'd1;
         mr = mr >> 1;
      end
      if (v == 32'd0) begin
         to_single = 32'd0;
      end else begin
         to_single = {1'b0, ex, mr[22:0]};
      end
   endfunction

endpackage

// File: rtl/core/sffe_encode.sv
// ----------------------------------------------------------------------------
// sffe_encode
// Input stage: converts the sample combinationally and tracks channel and mask in registers.
// ----------------------------------------------------------------------------
module sffe_encode #(
   parameter int CHANNELS = sffe_pkg::CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  sffe_pkg::req_type  req,
   output sffe_pkg::frag_type frag
);
   logic [3:0]  chan_ff, chan_in;
   logic [15:0] mask_ff, mask_in;
   logic [15:0] mask_now;
   logic        last;
   logic [31:0] fbits;

   assign last = chan_ff >= 4'(CHANNELS - 1);
   assign fbits = sffe_pkg::to_single(req.raw_value);
   assign mask_now = req.sample_valid ? (mask_ff | (16'd1 << chan_ff)) : mask_ff;

   always_comb begin
      frag.last = last;
      frag.bytes = {sffe_pkg::TAIL_B3, sffe_pkg::TAIL_B2, sffe_pkg::TAIL_B1,
                    sffe_pkg::TAIL_B0, mask_now, fbits};
      chan_in = chan_ff;
      mask_in = mask_ff;
      if (take) begin
         chan_in = last ? 4'd0 : chan_ff + 4'd1;
         mask_in = last ? 16'd0 : mask_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= 4'd0;
         mask_ff <= 16'd0;
      end else begin
         chan_ff <= chan_in;
         mask_ff <= mask_in;
      end
   end
endmodule

// File: rtl/core/sffe_serial.sv
// ----------------------------------------------------------------------------
// sffe_serial
// Holds one encoded fragment and shifts it out a byte per cycle while the result port is not stalled.
// ----------------------------------------------------------------------------
module sffe_serial (
   input  logic               clock,
   input  logic               reset,
   input  sffe_pkg::frag_type frag,
   input  logic               load,
   output logic               empty,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sffe_pkg::rsp_type  rsp_data
);
   logic [79:0] buf_ff, buf_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        fl_ff, fl_in;
   logic        pop;

   assign rsp_valid = cnt_ff != 4'd0;
   assign pop = rsp_valid && !rsp_stall;
   // free when empty or popping the final byte
   assign empty = !rsp_valid || (pop && cnt_ff == 4'd1);
   assign rsp_data.out_byte = buf_ff[7:0];
   assign rsp_data.run_last = cnt_ff == 4'd1;
   assign rsp_data.frame_last = cnt_ff == 4'd1 && fl_ff;

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      fl_in = fl_ff;
      if (pop) begin
         buf_in = buf_ff >> 8;
         cnt_in = cnt_ff - 4'd1;
      end
      if (load) begin
         buf_in = frag.bytes;
         cnt_in = frag.last ? 4'd10 : 4'd4;
         fl_in = frag.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
         fl_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         fl_ff <= fl_in;
      end
      buf_ff <= buf_in;
   end
endmodule

// File: rtl/core/sample_float_frame_encoder.sv
// Latency: a result byte is shown the cycle after its request is accepted.
// Flow: each request yields 4 result bytes (10 for the last channel), sent one per
// cycle unless stalled; a new request is taken as the last byte leaves.
// Reset: synchronous; clears channel count and valid mask and empties the output buffer.
// ----------------------------------------------------------------------------
// sample_float_frame_encoder
// Converts channel samples to single floats and frames them as bytes.
// ----------------------------------------------------------------------------
module sample_float_frame_encoder #(
   parameter int CHANNELS = sffe_pkg::CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sffe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sffe_pkg::rsp_type rsp_data
);
   sffe_pkg::frag_type frag;
   logic empty;
   logic take;

   assign req_stall = !empty;
   assign take = req_valid && empty;

   sffe_encode #(.CHANNELS(CHANNELS)) u_enc (
      .clock(clock), .reset(reset), .take(take), .req(req_data), .frag(frag)
   );

   sffe_serial u_ser (
      .clock(clock), .reset(reset), .frag(frag), .load(take), .empty(empty),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule

// File: rtl/core/sffe_checker.sv
// ----------------------------------------------------------------------------
// sffe_checker
// Port-level checks on the frame encoder.
// ----------------------------------------------------------------------------
module sffe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sffe_pkg::rsp_type rsp_data
);
   a_frame_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_last |-> rsp_data.run_last)
      else $error("frame end without run end");
   a_tail_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_last |-> rsp_data.out_byte == sffe_pkg::TAIL_B3)
      else $error("bad tail byte");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.run_last |-> req_stall)
      else $error("request taken mid run");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no byte");
endmodule

bind sample_float_frame_encoder sffe_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
